// File: rtl/djb2_linear_probe_insert_core_assert.svh
// assertion helpers for the djb2 linear probe insert core
`ifndef DJB2_LINEAR_PROBE_INSERT_CORE_ASSERT_SVH
`define DJB2_LINEAR_PROBE_INSERT_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DJB2LP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DJB2LP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/djb2lp_pkg.sv
`timescale 1ns / 1ps

package djb2lp_pkg;

    // hash constants
    localparam int HASH_W = 32;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam int HASH_SHIFT = 5;

    // iterative modulo: one quotient bit per cycle
    localparam int DIV_STEPS = HASH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration register
    localparam int TSIZE_W = 13;
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 13'd4096;

    // result fields
    localparam int STATUS_W = 2;
    localparam int SLOT_W = 12;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_EMIT
    } t_state;

endpackage

// File: rtl/djb2lp_ram.sv
`timescale 1ns / 1ps

module djb2lp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/djb2_linear_probe_insert_core.sv
`timescale 1ns / 1ps
// name bytes: taken only while idle; a name byte that is not last produces no result
// insert: take the last byte, bit-serial modulo, then per probed slot a memory read and then a
//   check and write, then emit (an empty name goes straight to emit)
// clear: clearing pass (one slot a cycle), then emit
// reset: clearing pass; no input is taken until it ends

module djb2_linear_probe_insert_core #(
    parameter int TABLE_DEPTH = 4096,
    parameter int INDEX_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: table_size
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [23:8] entry_index
    input  logic        s_axis_tuser,   // [0] command
    input  logic        s_axis_tlast,   // last_char
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] slot, [15:12] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (SZ_W > djb2lp_pkg::TSIZE_W) ? SZ_W : djb2lp_pkg::TSIZE_W;
    localparam int MEM_W = INDEX_WIDTH + 1;
    localparam int HW    = djb2lp_pkg::HASH_W;

    // control and payload registers
    djb2lp_pkg::t_state r_state, n_state;
    logic [djb2lp_pkg::TSIZE_W-1:0] r_table_size;
    logic [HW-1:0]                  r_hash, n_hash;
    logic                           r_name_ended, n_name_ended;
    logic                           r_name_nonempty, n_name_nonempty;
    logic [HW-1:0]                  r_quo, n_quo;
    logic [SZ_W-1:0]                r_rem, n_rem;
    logic [djb2lp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]                  r_key, n_key;
    logic [SZ_W-1:0]                r_tries, n_tries;
    logic [INDEX_WIDTH-1:0]         r_entry, n_entry;
    logic [AW-1:0]                  r_clr_addr, n_clr_addr;
    logic                           r_clr_report, n_clr_report;
    djb2lp_pkg::t_status            r_res_status, n_res_status;
    logic [djb2lp_pkg::SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic                           r_m_valid, n_m_valid;
    djb2lp_pkg::t_status            r_m_status, n_m_status;
    logic [djb2lp_pkg::SLOT_W-1:0]  r_m_slot, n_m_slot;

    // memory port
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [MEM_W-1:0] w_ram_wdata;
    logic [MEM_W-1:0] w_ram_rdata;

    // datapath helpers
    logic [CMP_W-1:0] w_ts_ext;
    logic [SZ_W-1:0]  w_eff;
    logic [7:0]       w_char;
    logic [15:0]      w_entry_in;
    logic [HW-1:0]    w_hash_step;
    logic [SZ_W:0]    w_div_t;
    logic [SZ_W:0]    w_div_d;
    logic [SZ_W-1:0]  w_key_inc;
    logic             w_in_acc;

    assign w_char     = s_axis_tdata[7:0];
    assign w_entry_in = s_axis_tdata[23:8];
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;

    // effective size: zero acts as one, clamp to the table depth
    assign w_ts_ext = CMP_W'(r_table_size);
    always_comb begin
        if (r_table_size == '0) begin
            w_eff = SZ_W'(1);
        end else if (w_ts_ext > CMP_W'(TABLE_DEPTH)) begin
            w_eff = SZ_W'(TABLE_DEPTH);
        end else begin
            w_eff = SZ_W'(w_ts_ext);
        end
    end

    // djb2 step: hash * 33 + byte
    assign w_hash_step = (r_hash << djb2lp_pkg::HASH_SHIFT) + r_hash + HW'(w_char);

    // restoring division step on the remainder
    assign w_div_t = {r_rem, r_quo[HW-1]};
    assign w_div_d = {1'b0, w_eff};

    // next probe slot before wrap
    assign w_key_inc = SZ_W'(r_key) + SZ_W'(1);

    assign s_axis_tready = (r_state == djb2lp_pkg::S_IDLE);

    djb2lp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_key),
        .o_rdata (w_ram_rdata)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= djb2lp_pkg::TSIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_table_size <= i_cfg_wr_data;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= djb2lp_pkg::S_CLEAR;
            r_hash          <= djb2lp_pkg::HASH_SEED;
            r_name_ended    <= 1'b0;
            r_name_nonempty <= 1'b0;
            r_clr_addr      <= '0;
            r_clr_report    <= 1'b0;
            r_m_valid       <= 1'b0;
            r_cnt           <= '0;
        end else begin
            r_state         <= n_state;
            r_hash          <= n_hash;
            r_name_ended    <= n_name_ended;
            r_name_nonempty <= n_name_nonempty;
            r_clr_addr      <= n_clr_addr;
            r_clr_report    <= n_clr_report;
            r_m_valid       <= n_m_valid;
            r_cnt           <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_key        <= n_key;
        r_tries      <= n_tries;
        r_entry      <= n_entry;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_m_status   <= n_m_status;
        r_m_slot     <= n_m_slot;
    end

    // next state and datapath
    always_comb begin
        n_state         = r_state;
        n_hash          = r_hash;
        n_name_ended    = r_name_ended;
        n_name_nonempty = r_name_nonempty;
        n_quo           = r_quo;
        n_rem           = r_rem;
        n_cnt           = r_cnt;
        n_key           = r_key;
        n_tries         = r_tries;
        n_entry         = r_entry;
        n_clr_addr      = r_clr_addr;
        n_clr_report    = r_clr_report;
        n_res_status    = r_res_status;
        n_res_slot      = r_res_slot;
        n_m_valid       = r_m_valid;
        n_m_status      = r_m_status;
        n_m_slot        = r_m_slot;
        w_ram_we        = 1'b0;
        w_ram_waddr     = r_key;
        w_ram_wdata     = {1'b1, r_entry};

        // output register drains on take
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            // sweep every slot empty
            djb2lp_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_clr_addr = '0;
                    if (r_clr_report) begin
                        n_res_status = djb2lp_pkg::ST_CLEARED;
                        n_res_slot   = '0;
                        n_state      = djb2lp_pkg::S_EMIT;
                    end else begin
                        n_state = djb2lp_pkg::S_IDLE;
                    end
                end
            end

            // take name bytes and commands
            djb2lp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == djb2lp_pkg::CMD_CLEAR) begin
                        n_hash          = djb2lp_pkg::HASH_SEED;
                        n_name_ended    = 1'b0;
                        n_name_nonempty = 1'b0;
                        n_clr_addr      = '0;
                        n_clr_report    = 1'b1;
                        n_state         = djb2lp_pkg::S_CLEAR;
                    end else begin
                        if (!r_name_ended) begin
                            if (w_char == 8'd0) begin
                                n_name_ended = 1'b1;
                            end else begin
                                n_hash          = w_hash_step;
                                n_name_nonempty = 1'b1;
                            end
                        end
                        if (s_axis_tlast) begin
                            n_quo           = n_hash;
                            n_rem           = '0;
                            n_cnt           = '0;
                            n_tries         = '0;
                            n_entry         = INDEX_WIDTH'(w_entry_in);
                            n_res_slot      = '0;
                            n_res_status    = djb2lp_pkg::ST_EMPTY;
                            n_state         = n_name_nonempty ? djb2lp_pkg::S_DIV
                                                              : djb2lp_pkg::S_EMIT;
                            n_hash          = djb2lp_pkg::HASH_SEED;
                            n_name_ended    = 1'b0;
                            n_name_nonempty = 1'b0;
                        end
                    end
                end
            end

            // hash modulo size, one bit a cycle
            djb2lp_pkg::S_DIV: begin
                if (w_div_t >= w_div_d) begin
                    n_rem = SZ_W'(w_div_t - w_div_d);
                end else begin
                    n_rem = SZ_W'(w_div_t);
                end
                n_quo = r_quo << 1;
                n_cnt = r_cnt + djb2lp_pkg::DIV_CNT_W'(1);
                if (r_cnt == djb2lp_pkg::DIV_CNT_W'(djb2lp_pkg::DIV_STEPS - 1)) begin
                    n_key   = AW'(n_rem);
                    n_state = djb2lp_pkg::S_RD;
                end
            end

            // slot read in flight
            djb2lp_pkg::S_RD: begin
                n_state = djb2lp_pkg::S_CHK;
            end

            // store into an empty slot, report full once every slot was probed, or move on
            djb2lp_pkg::S_CHK: begin
                if (!w_ram_rdata[MEM_W-1]) begin
                    w_ram_we     = 1'b1;
                    n_res_status = djb2lp_pkg::ST_STORED;
                    n_res_slot   = djb2lp_pkg::SLOT_W'(r_key);
                    n_state      = djb2lp_pkg::S_EMIT;
                end else if (r_tries + SZ_W'(1) == w_eff) begin
                    n_res_status = djb2lp_pkg::ST_FULL;
                    n_res_slot   = '0;
                    n_state      = djb2lp_pkg::S_EMIT;
                end else begin
                    n_tries = r_tries + SZ_W'(1);
                    n_key   = (w_key_inc == w_eff) ? '0 : AW'(w_key_inc);
                    n_state = djb2lp_pkg::S_RD;
                end
            end

            // hand result to the output register once it is free
            djb2lp_pkg::S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_slot   = r_res_slot;
                    n_state    = djb2lp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = djb2lp_pkg::S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = 16'(r_m_slot);
    assign m_axis_tuser  = r_m_status;

    // checks
`include "djb2_linear_probe_insert_core_assert.svh"

    `DJB2LP_ASSERT_NOW(a_rem_in_range, r_state == djb2lp_pkg::S_DIV, r_rem < w_eff, "remainder not below table size")
    `DJB2LP_ASSERT_NOW(a_key_in_range, r_state == djb2lp_pkg::S_CHK, SZ_W'(r_key) < w_eff, "probe slot beyond table size")
    `DJB2LP_ASSERT_NOW(a_probe_bound, r_state == djb2lp_pkg::S_CHK, r_tries < w_eff, "probe ran past table size")
    `DJB2LP_ASSERT_NOW(a_no_overwrite, w_ram_we && r_state == djb2lp_pkg::S_CHK, !w_ram_rdata[MEM_W-1], "insert overwrote an occupied slot")
    `DJB2LP_ASSERT_NEXT(a_emit_loads, r_state == djb2lp_pkg::S_EMIT && !r_m_valid, r_m_valid, "result not loaded into free output register")

endmodule

// File: verif/djb2_linear_probe_insert_core_tb.sv
`timescale 1ns / 1ps

module djb2_linear_probe_insert_core_tb;

    localparam int DEPTH = 4096;
    localparam int IDX_W = 16;
    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 100;

    // one name request as seen on the input stream
    typedef struct packed {
        logic             cmd;
        logic [7:0]       ch;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_name_req;

    typedef struct packed {
        djb2lp_pkg::t_status           status;
        logic [djb2lp_pkg::SLOT_W-1:0] slot;
    } t_insert_result;

    // directed row: either a table size write or a request
    typedef struct packed {
        logic                           is_cfg;
        logic [djb2lp_pkg::TSIZE_W-1:0] cfg_val;
        t_name_req                      req;
        logic                           typed;
        t_insert_result                 res;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [12:0]        i_cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic [1:0]         m_axis_tuser;

    // predictor state
    logic [djb2lp_pkg::TSIZE_W-1:0] size_reg;
    logic [djb2lp_pkg::HASH_W-1:0]  name_hash;
    logic                           name_done;
    logic                           name_has_bytes;
    bit                             slot_taken [DEPTH];
    t_insert_result                 pending_results[$];

    int                 error_count = 0;
    bit                 gapless = 1'b0;
    int                 burst_left = 0;
    bit                 hold_off_req = 1'b0;

    djb2_linear_probe_insert_core #(
        .TABLE_DEPTH(DEPTH),
        .INDEX_WIDTH(IDX_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop if the block hangs
    initial begin
        #1_000_000_000;
        $display("FAIL djb2_linear_probe_insert_core");
        $finish;
    end

    task automatic restart_name_state();
        name_hash = djb2lp_pkg::HASH_SEED;
        name_done = 1'b0;
        name_has_bytes = 1'b0;
    endtask

    // hash fold, modulo and linear probe for one accepted request
    task automatic predict_insert(input t_name_req r, output bit produced,
                                  output t_insert_result res);
        int unsigned sz;
        int unsigned key;
        produced = 1'b0;
        res.status = djb2lp_pkg::ST_STORED;
        res.slot = '0;
        if (r.cmd == djb2lp_pkg::CMD_CLEAR) begin
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            restart_name_state();
            produced = 1'b1;
            res.status = djb2lp_pkg::ST_CLEARED;
            return;
        end
        // a zero byte ends the name, later bytes are not hashed
        if (!name_done) begin
            if (r.ch == 8'd0) begin
                name_done = 1'b1;
            end else begin
                name_hash = (name_hash << djb2lp_pkg::HASH_SHIFT) + name_hash
                            + {24'd0, r.ch};
                name_has_bytes = 1'b1;
            end
        end
        if (!r.last) return;
        produced = 1'b1;
        if (!name_has_bytes) begin
            res.status = djb2lp_pkg::ST_EMPTY;
        end else begin
            // size zero acts as one, oversize is clipped to the depth
            sz = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : size_reg;
            key = name_hash % sz;
            res.status = djb2lp_pkg::ST_FULL;
            for (int n = 0; n < sz; n++) begin
                if (!slot_taken[key]) begin
                    slot_taken[key] = 1'b1;
                    res.status = djb2lp_pkg::ST_STORED;
                    res.slot = djb2lp_pkg::SLOT_W'(key);
                    break;
                end
                key = key + 1;
                if (key >= sz) key = 0;
            end
        end
        restart_name_state();
    endtask

    // offer one request, bursting with random gaps unless gapless
    task automatic send_item(input t_name_req r, input bit typed,
                             input t_insert_result typed_res);
        bit produced;
        t_insert_result res;
        int gap;
        if (!gapless) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = r.cmd;
        s_axis_tlast = r.last;
        s_axis_tdata = {r.idx, r.ch};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_insert(r, produced, res);
        if (produced) pending_results.push_back(typed ? typed_res : res);
    endtask

    // stop sending and let every expected result drain
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
    endtask

    task automatic write_table_size(input logic [djb2lp_pkg::TSIZE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        size_reg = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    function automatic t_dir_row row(logic cmd, logic [7:0] ch, logic last,
                                     logic [IDX_W-1:0] idx, logic typed = 1'b0,
                                     djb2lp_pkg::t_status st = djb2lp_pkg::ST_STORED,
                                     logic [djb2lp_pkg::SLOT_W-1:0] sl = '0);
        t_dir_row d;
        d = '0;
        d.req.cmd = cmd;
        d.req.ch = ch;
        d.req.last = last;
        d.req.idx = idx;
        d.typed = typed;
        d.res.status = st;
        d.res.slot = sl;
        return d;
    endfunction

    function automatic t_dir_row cfg_row(logic [djb2lp_pkg::TSIZE_W-1:0] v);
        t_dir_row d;
        d = '0;
        d.is_cfg = 1'b1;
        d.cfg_val = v;
        return d;
    endfunction

    // receiver: random stretches of always-ready, random and periodic stalls
    initial begin
        int mode;
        int stretch_left;
        int hold_left;
        int cyc;
        mode = 0;
        stretch_left = 0;
        hold_left = 0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(20, 200);
                end
                stretch_left--;
                case (mode)
                    0: begin
                        m_axis_tready = 1'b1;
                    end
                    1: begin
                        m_axis_tready = ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_axis_tready = ((cyc % 5) < 2);
                    end
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_insert_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, m_axis_tuser, m_axis_tdata[11:0]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[11:0] !== want.slot) begin
                    $display("%0t: slot mismatch, expected %0d, actual %0d",
                             $time, want.slot, m_axis_tdata[11:0]);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_dir_row rows[$];
        t_name_req r;
        t_insert_result none;
        int phase_sizes[PHASES];
        int sent;
        int len;
        int zero_at;
        int kind;

        none = '0;
        phase_sizes = '{4096, 0, 1, 2, 3, 8, 17, 64, 255, 1000, 4095, 8191, 4097, 4096};
        size_reg = djb2lp_pkg::TSIZE_RESET;
        restart_name_state();

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait for the clearing pass after reset
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);

        // clear ignores its other fields, empty name, repeat and high bytes
        rows.push_back(row(djb2lp_pkg::CMD_CLEAR, 8'hFF, 1'b1, 16'hFFFF, 1'b1,
                           djb2lp_pkg::ST_CLEARED, '0));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h00, 1'b1, 16'h0000, 1'b1,
                           djb2lp_pkg::ST_EMPTY, '0));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h61, 1'b1, 16'h0000));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h61, 1'b1, 16'hFFFF));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'hFF, 1'b0, 16'h0000));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h80, 1'b0, 16'hFFFF));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h01, 1'b1, 16'h1234));
        // bytes after a zero are not hashed
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h78, 1'b0, 16'h0001));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h00, 1'b0, 16'h0002));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h79, 1'b1, 16'h0003));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h00, 1'b0, 16'h0004));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h7A, 1'b1, 16'h0005, 1'b1,
                           djb2lp_pkg::ST_EMPTY, '0));
        // clear drops a name in progress
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h71, 1'b0, 16'h0006));
        rows.push_back(row(djb2lp_pkg::CMD_CLEAR, 8'h00, 1'b0, 16'h0000, 1'b1,
                           djb2lp_pkg::ST_CLEARED, '0));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h71, 1'b1, 16'h0007));
        // size zero acts as one slot
        rows.push_back(cfg_row(13'd0));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h62, 1'b1, 16'h0008, 1'b1,
                           djb2lp_pkg::ST_STORED, '0));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h63, 1'b1, 16'h0009, 1'b1,
                           djb2lp_pkg::ST_FULL, '0));
        // oversize is clipped
        rows.push_back(cfg_row(13'h1FFF));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h61, 1'b1, 16'h00AA));
        // two slots fill up
        rows.push_back(cfg_row(13'd2));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h64, 1'b0, 16'h0000));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h65, 1'b1, 16'h8000));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h66, 1'b1, 16'h7FFF));
        rows.push_back(row(djb2lp_pkg::CMD_INSERT, 8'h67, 1'b1, 16'h5555));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_drained();
                write_table_size(rows[i].cfg_val);
            end else begin
                send_item(rows[i].req, rows[i].typed, rows[i].res);
            end
        end

        // random phases, one table size each
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_table_size(djb2lp_pkg::TSIZE_W'(phase_sizes[p]));
            gapless = (p % 3 == 0);
            // the long receiver hold-off starts on an idle block
            if (p != 6 && $urandom_range(0, 1) == 1) begin
                r = '0;
                r.cmd = djb2lp_pkg::CMD_CLEAR;
                send_item(r, 1'b0, none);
            end
            if (p == 6) hold_off_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 75) begin
                    // well-formed name, sometimes with an early zero
                    len = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 5);
                    zero_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
                    for (int k = 0; k < len; k++) begin
                        r.cmd = djb2lp_pkg::CMD_INSERT;
                        r.ch = (k == zero_at) ? 8'd0 : 8'($urandom_range(1, 255));
                        r.last = (k == len - 1);
                        r.idx = IDX_W'($urandom_range(0, 65535));
                        send_item(r, 1'b0, none);
                        sent++;
                    end
                end else if (kind < 85) begin
                    // single noise byte
                    r.cmd = djb2lp_pkg::CMD_INSERT;
                    r.ch = 8'($urandom_range(0, 255));
                    r.last = 1'($urandom_range(0, 1));
                    r.idx = IDX_W'($urandom_range(0, 65535));
                    send_item(r, 1'b0, none);
                    sent++;
                end else if (kind < 87) begin
                    // clear with random junk in the other fields
                    r.cmd = djb2lp_pkg::CMD_CLEAR;
                    r.ch = 8'($urandom_range(0, 255));
                    r.last = 1'($urandom_range(0, 1));
                    r.idx = IDX_W'($urandom_range(0, 65535));
                    send_item(r, 1'b0, none);
                    sent++;
                end else begin
                    // broken name: bytes with no last marker
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        r.cmd = djb2lp_pkg::CMD_INSERT;
                        r.ch = 8'($urandom_range(0, 255));
                        r.last = 1'b0;
                        r.idx = IDX_W'($urandom_range(0, 65535));
                        send_item(r, 1'b0, none);
                        sent++;
                    end
                end
            end
            // close any open name before the next size change
            r.cmd = djb2lp_pkg::CMD_INSERT;
            r.ch = 8'($urandom_range(1, 255));
            r.last = 1'b1;
            r.idx = IDX_W'($urandom_range(0, 65535));
            send_item(r, 1'b0, none);
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (error_count == 0) begin
            $display("PASS djb2_linear_probe_insert_core");
        end else begin
            $display("FAIL djb2_linear_probe_insert_core");
        end
        $finish;
    end

endmodule
